// ----- rtl/window_spread_detector_macros.svh -----
// ----------------------------------------------------------------------------
// Window spread detector assertion macros
// Shared clocked assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef WINDOW_SPREAD_DETECTOR_MACROS_SVH
`define WINDOW_SPREAD_DETECTOR_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define WSD_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("window_spread_detector: assertion failed");

// Expression must never be true outside reset.
`define WSD_ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("window_spread_detector: forbidden condition seen");

`endif

// ----- rtl/wsd_pkg.sv -----
// ----------------------------------------------------------------------------
// Window spread detector package
// Default sizes, register field widths and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package wsd_pkg;

   localparam int DEF_MAX_WINDOW  = 64;
   localparam int DEF_SAMPLE_BITS = 16;
   localparam int DEF_INDEX_BITS  = 20;
   localparam int DEF_LEN_BITS    = $clog2(DEF_MAX_WINDOW + 1);

   localparam int CFG_LEN_BITS    = 7;
   localparam int CFG_SPREAD_BITS = 16;
   localparam int CSR_DATA_BITS   = 16;
   localparam int CSR_INDEX_BITS  = 1;

   localparam logic [CFG_LEN_BITS-1:0]    RST_WINDOW_LENGTH = 7'd8;
   localparam logic [CFG_SPREAD_BITS-1:0] RST_MAX_SPREAD    = 16'd0;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_WINDOW_LENGTH = 1'b0,
      CSR_MAX_SPREAD    = 1'b1
   } csr_index_type;

endpackage

`default_nettype wire

// ----- rtl/wsd_if.sv -----
// ----------------------------------------------------------------------------
// Window spread detector channels
// Sample input, result output and register write channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface wsd_req_if #(
   parameter int SAMPLE_BITS = wsd_pkg::DEF_SAMPLE_BITS
) ();
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] sample;
   logic                   end_of_series;

   modport source (output valid, sample, end_of_series, input ready);
   modport sink   (input valid, sample, end_of_series, output ready);
endinterface

interface wsd_rsp_if #(
   parameter int INDEX_BITS = wsd_pkg::DEF_INDEX_BITS
) ();
   logic                  valid;
   logic                  ready;
   logic [INDEX_BITS-1:0] window_start;

   modport source (output valid, window_start, input ready);
   modport sink   (input valid, window_start, output ready);
endinterface

interface wsd_csr_if ();
   logic                                valid;
   logic                                ready;
   logic [wsd_pkg::CSR_INDEX_BITS-1:0] index;
   logic [wsd_pkg::CSR_DATA_BITS-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/window_spread_detector.sv -----
// Flow: an accepted item moves the FSM to launch, the min/max wave then
// crosses the chain one cell per cycle, and decide loads any result.
// req ready only when idle: a new item waits until the last one is decided.
// A held result lets the next item in; a second hit waits until it is taken.
// Synchronous active-high reset clears control, fill count, position and
// registers (window_length 8, max_spread 0); window samples are not cleared.
// ----------------------------------------------------------------------------
// Window spread detector
// Sliding window peak-to-peak check over a chain of sample cells.
// ----------------------------------------------------------------------------
`default_nettype none

module window_spread_detector #(
   parameter int MAX_WINDOW  = wsd_pkg::DEF_MAX_WINDOW,
   parameter int SAMPLE_BITS = wsd_pkg::DEF_SAMPLE_BITS,
   parameter int INDEX_BITS  = wsd_pkg::DEF_INDEX_BITS
) (
   input wire logic clock,
   input wire logic reset,
   wsd_req_if.sink   req_chan,
   wsd_rsp_if.source rsp_chan,
   wsd_csr_if.sink   csr_chan
);
   import wsd_pkg::*;

   localparam int LEN_BITS = $clog2(MAX_WINDOW + 1);
   localparam int CMP_BITS = (SAMPLE_BITS > CFG_SPREAD_BITS) ? SAMPLE_BITS : CFG_SPREAD_BITS;

   typedef enum logic [1:0] {
      S_IDLE,
      S_LAUNCH,
      S_SCAN,
      S_DECIDE
   } state_type;

   state_type state_ff;

   logic [CFG_LEN_BITS-1:0]    win_len_ff;
   logic [CFG_SPREAD_BITS-1:0] max_spread_ff;
   logic [LEN_BITS-1:0]        fill_ff, fill_in;
   logic [INDEX_BITS-1:0]      pos_ff, pos_in;
   logic [INDEX_BITS-1:0]      start_ff, start_in;
   logic                       check_ff, check_in;
   logic                       hit_ff;
   logic                       rsp_valid_ff;
   logic [INDEX_BITS-1:0]      rsp_start_ff;

   logic [LEN_BITS-1:0]        eff_len;
   logic                       req_acc;
   logic                       rsp_load;
   logic                       chain_done;
   logic [SAMPLE_BITS-1:0]     chain_lo, chain_hi, spread;
   logic [CMP_BITS-1:0]        spread_cmp, limit_cmp;

   // registers
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_len_ff    <= RST_WINDOW_LENGTH;
         max_spread_ff <= RST_MAX_SPREAD;
      end else if (csr_chan.valid) begin
         case (csr_index_type'(csr_chan.index))
            CSR_WINDOW_LENGTH: win_len_ff    <= csr_chan.data[CFG_LEN_BITS-1:0];
            CSR_MAX_SPREAD:    max_spread_ff <= csr_chan.data[CFG_SPREAD_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (win_len_ff == '0) begin
         eff_len = LEN_BITS'(1);
      end else if (int'(win_len_ff) > MAX_WINDOW) begin
         eff_len = LEN_BITS'(MAX_WINDOW);
      end else begin
         eff_len = LEN_BITS'(win_len_ff);
      end
   end

   // series bookkeeping at accept
   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_acc        = req_chan.valid && req_chan.ready;

   always_comb begin
      fill_in  = fill_ff;
      if (fill_ff != LEN_BITS'(MAX_WINDOW)) begin
         fill_in = fill_ff + LEN_BITS'(1);
      end
      pos_in   = pos_ff + INDEX_BITS'(1);
      start_in = pos_in + INDEX_BITS'(1) - INDEX_BITS'(eff_len);
      check_in = (fill_in >= eff_len);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         pos_ff  <= '0;
      end else if (req_acc) begin
         if (req_chan.end_of_series) begin
            fill_ff <= '0;
            pos_ff  <= '0;
         end else begin
            fill_ff <= fill_in;
            pos_ff  <= pos_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         start_ff <= start_in;
         check_ff <= check_in;
      end
   end

   wsd_chain #(
      .MAX_WINDOW  (MAX_WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS),
      .LEN_BITS    (LEN_BITS)
   ) u_chain (
      .clock      (clock),
      .reset      (reset),
      .shift_en   (req_acc),
      .sample_in  (req_chan.sample),
      .launch     (state_ff == S_LAUNCH),
      .launch_len (eff_len),
      .done       (chain_done),
      .result_lo  (chain_lo),
      .result_hi  (chain_hi)
   );

   assign spread     = chain_hi - chain_lo;
   assign spread_cmp = CMP_BITS'(spread);
   assign limit_cmp  = CMP_BITS'(max_spread_ff);

   assign rsp_load = (state_ff == S_DECIDE) && hit_ff && (!rsp_valid_ff || rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
            rsp_start_ff <= start_ff;
         end else if (rsp_valid_ff && rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_acc) begin
                  state_ff <= S_LAUNCH;
               end
            end
            S_LAUNCH: begin
               state_ff <= S_SCAN;
            end
            S_SCAN: begin
               if (chain_done) begin
                  hit_ff   <= check_ff && (spread_cmp <= limit_cmp);
                  state_ff <= S_DECIDE;
               end
            end
            S_DECIDE: begin
               if (!hit_ff || rsp_load) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.window_start = rsp_start_ff;

endmodule

`default_nettype wire

// ----- rtl/wsd_cell.sv -----
// ----------------------------------------------------------------------------
// Window spread detector cell
// Holds one window sample and folds it into the min/max wave passing by.
// ----------------------------------------------------------------------------
`default_nettype none

module wsd_cell #(
   parameter int SAMPLE_BITS = wsd_pkg::DEF_SAMPLE_BITS,
   parameter int LEN_BITS    = wsd_pkg::DEF_LEN_BITS
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   shift_en,
   input  wire logic [SAMPLE_BITS-1:0] sample_in,
   output logic      [SAMPLE_BITS-1:0] sample_out,
   input  wire logic                   wave_valid_in,
   input  wire logic [LEN_BITS-1:0]    wave_remain_in,
   input  wire logic [SAMPLE_BITS-1:0] wave_lo_in,
   input  wire logic [SAMPLE_BITS-1:0] wave_hi_in,
   output logic                        wave_valid_out,
   output logic      [LEN_BITS-1:0]    wave_remain_out,
   output logic      [SAMPLE_BITS-1:0] wave_lo_out,
   output logic      [SAMPLE_BITS-1:0] wave_hi_out
);
   import wsd_pkg::*;

   logic [SAMPLE_BITS-1:0] sample_ff;
   logic                   wave_valid_ff;
   logic [LEN_BITS-1:0]    remain_ff, remain_in;
   logic [SAMPLE_BITS-1:0] lo_ff, lo_in;
   logic [SAMPLE_BITS-1:0] hi_ff, hi_in;
   logic                   take;

   // this cell is inside the window while the wave still has samples to cover
   assign take = wave_valid_in && (wave_remain_in != '0);

   always_comb begin
      remain_in = wave_remain_in;
      lo_in     = wave_lo_in;
      hi_in     = wave_hi_in;
      if (take) begin
         remain_in = wave_remain_in - LEN_BITS'(1);
         if (sample_ff < wave_lo_in) begin
            lo_in = sample_ff;
         end
         if (sample_ff > wave_hi_in) begin
            hi_in = sample_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wave_valid_ff <= 1'b0;
      end else begin
         wave_valid_ff <= wave_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         sample_ff <= sample_in;
      end
      remain_ff <= remain_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
   end

   assign sample_out      = sample_ff;
   assign wave_valid_out  = wave_valid_ff;
   assign wave_remain_out = remain_ff;
   assign wave_lo_out     = lo_ff;
   assign wave_hi_out     = hi_ff;

endmodule

`default_nettype wire

// ----- rtl/wsd_chain.sv -----
// ----------------------------------------------------------------------------
// Window spread detector cell chain
// Sample shift line of MAX_WINDOW cells with a min/max wave running along it.
// ----------------------------------------------------------------------------
`default_nettype none

module wsd_chain #(
   parameter int MAX_WINDOW  = wsd_pkg::DEF_MAX_WINDOW,
   parameter int SAMPLE_BITS = wsd_pkg::DEF_SAMPLE_BITS,
   parameter int LEN_BITS    = wsd_pkg::DEF_LEN_BITS
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   shift_en,
   input  wire logic [SAMPLE_BITS-1:0] sample_in,
   input  wire logic                   launch,
   input  wire logic [LEN_BITS-1:0]    launch_len,
   output logic                        done,
   output logic      [SAMPLE_BITS-1:0] result_lo,
   output logic      [SAMPLE_BITS-1:0] result_hi
);
   import wsd_pkg::*;

   logic [SAMPLE_BITS-1:0] samp_link   [0:MAX_WINDOW-1];
   logic                   valid_link  [0:MAX_WINDOW];
   logic [LEN_BITS-1:0]    remain_link [0:MAX_WINDOW];
   logic [SAMPLE_BITS-1:0] lo_link     [0:MAX_WINDOW];
   logic [SAMPLE_BITS-1:0] hi_link     [0:MAX_WINDOW];

   assign samp_link[0]   = sample_in;
   assign valid_link[0]  = launch;
   assign remain_link[0] = launch_len;
   assign lo_link[0]     = '1;
   assign hi_link[0]     = '0;

   for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
      if (i < MAX_WINDOW - 1) begin : g_mid
         wsd_cell #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .LEN_BITS    (LEN_BITS)
         ) u_cell (
            .clock           (clock),
            .reset           (reset),
            .shift_en        (shift_en),
            .sample_in       (samp_link[i]),
            .sample_out      (samp_link[i+1]),
            .wave_valid_in   (valid_link[i]),
            .wave_remain_in  (remain_link[i]),
            .wave_lo_in      (lo_link[i]),
            .wave_hi_in      (hi_link[i]),
            .wave_valid_out  (valid_link[i+1]),
            .wave_remain_out (remain_link[i+1]),
            .wave_lo_out     (lo_link[i+1]),
            .wave_hi_out     (hi_link[i+1])
         );
      end else begin : g_last
         wsd_cell #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .LEN_BITS    (LEN_BITS)
         ) u_cell (
            .clock           (clock),
            .reset           (reset),
            .shift_en        (shift_en),
            .sample_in       (samp_link[i]),
            .sample_out      (),
            .wave_valid_in   (valid_link[i]),
            .wave_remain_in  (remain_link[i]),
            .wave_lo_in      (lo_link[i]),
            .wave_hi_in      (hi_link[i]),
            .wave_valid_out  (valid_link[i+1]),
            .wave_remain_out (remain_link[i+1]),
            .wave_lo_out     (lo_link[i+1]),
            .wave_hi_out     (hi_link[i+1])
         );
      end
   end

   assign done      = valid_link[MAX_WINDOW];
   assign result_lo = lo_link[MAX_WINDOW];
   assign result_hi = hi_link[MAX_WINDOW];

endmodule

`default_nettype wire

// ----- rtl/wsd_checker.sv -----
// ----------------------------------------------------------------------------
// Window spread detector checker
// Port-level checks on handshake timing, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "window_spread_detector_macros.svh"

module wsd_checker #(
   parameter int INDEX_BITS = wsd_pkg::DEF_INDEX_BITS
) (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_valid,
   input wire logic                  req_ready,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_ready,
   input wire logic [INDEX_BITS-1:0] rsp_window_start,
   input wire logic                  csr_ready
);
   import wsd_pkg::*;

   logic req_acc;

   assign req_acc = req_valid && req_ready;

   // one item in flight: busy right after an accept
   `WSD_ASSERT(a_busy_after_accept, clock, reset, req_acc |=> !req_ready)

   // a result never appears in the cycle right after an accept
   `WSD_ASSERT(a_no_early_result, clock, reset, req_acc |=> !$rose(rsp_valid))

   // a stalled result holds
   `WSD_ASSERT(a_rsp_hold, clock, reset,
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_window_start))

   // register writes are always taken
   `WSD_ASSERT_NEVER(a_csr_ready, clock, reset, !csr_ready)

endmodule

bind window_spread_detector wsd_checker #(
   .INDEX_BITS (INDEX_BITS)
) u_wsd_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_window_start (rsp_chan.window_start),
   .csr_ready        (csr_chan.ready)
);

`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Window spread detector testbench
// Streams samples with bursty valid and a stalling result side. Each item
// goes through a local window model that predicts the window start it
// reports, if any. Every reported start is compared against the oldest
// prediction. A short table runs first, then random series over several
// register settings.
// ----------------------------------------------------------------------------

module testbench;
   import wsd_pkg::*;

   localparam int WINDOW_CELLS = DEF_MAX_WINDOW;
   localparam int SAMPLE_W     = DEF_SAMPLE_BITS;
   localparam int POS_W        = DEF_INDEX_BITS;
   localparam int DRAIN_CYCLES = DEF_MAX_WINDOW + 2 + 10;
   localparam int HOLD_CYCLES  = 600;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type              kind;
      logic [SAMPLE_W-1:0]       value;
      logic                      eos;
      csr_index_type             idx;
      bit                        known;
      bit                        hit;
      logic [POS_W-1:0]          start;
   } stim_row_type;

   logic clock;
   logic reset;

   wsd_req_if req_bus ();
   wsd_rsp_if rsp_bus ();
   wsd_csr_if csr_bus ();

   window_spread_detector DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // window model state
   logic [SAMPLE_W-1:0]        held [WINDOW_CELLS];
   int unsigned                held_count;
   logic [POS_W-1:0]           position;
   logic [CFG_LEN_BITS-1:0]    cfg_length;
   logic [CFG_SPREAD_BITS-1:0] cfg_spread;

   logic [POS_W-1:0] pending_starts [$];
   stim_row_type     stim_table [$];
   stim_row_type     table_notes [$];

   int  errors;
   int  samples_taken;
   int  hits_seen;
   int  csr_writes;
   int  burst_left;
   bit  long_hold_wanted;

   bit               pred_hit;
   logic [POS_W-1:0] pred_start;
   logic [POS_W-1:0] exp_start;
   stim_row_type     note;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("FAIL");
      $finish;
   end

   function automatic void step_window(input logic [SAMPLE_W-1:0] s, input logic eos,
                                       output bit hit, output logic [POS_W-1:0] start);
      int unsigned         len;
      logic [SAMPLE_W-1:0] lo;
      logic [SAMPLE_W-1:0] hi;
      len = (cfg_length == 0) ? 1 : ((cfg_length > WINDOW_CELLS) ? WINDOW_CELLS : cfg_length);
      for (int i = WINDOW_CELLS - 1; i > 0; i--) held[i] = held[i-1];
      held[0] = s;
      if (held_count < WINDOW_CELLS) held_count++;
      position = position + 1'b1;
      hit   = 1'b0;
      start = '0;
      if (held_count >= len) begin
         lo = held[0];
         hi = held[0];
         for (int j = 1; j < len; j++) begin
            if (held[j] < lo) lo = held[j];
            if (held[j] > hi) hi = held[j];
         end
         if (hi - lo <= cfg_spread) begin
            hit   = 1'b1;
            start = position + 1'b1 - POS_W'(len);
         end
      end
      if (eos) begin
         held_count = 0;
         position   = '0;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            hits_seen++;
            if (pending_starts.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("unexpected window_start %0d", rsp_bus.window_start);
            end else begin
               exp_start = pending_starts.pop_front();
               if (exp_start !== rsp_bus.window_start) begin
                  errors++;
                  if (errors <= 10)
                     $display("window_start mismatch: expected %0d, got %0d",
                              exp_start, rsp_bus.window_start);
               end
            end
         end
         if (csr_bus.valid && csr_bus.ready) begin
            csr_writes++;
            if (csr_bus.index == CSR_WINDOW_LENGTH)
               cfg_length = csr_bus.data[CFG_LEN_BITS-1:0];
            else
               cfg_spread = csr_bus.data[CFG_SPREAD_BITS-1:0];
         end
         if (req_bus.valid && req_bus.ready) begin
            samples_taken++;
            step_window(req_bus.sample, req_bus.end_of_series, pred_hit, pred_start);
            if (table_notes.size() > 0) begin
               note = table_notes.pop_front();
               if (note.known) begin
                  pred_hit   = note.hit;
                  pred_start = note.start;
               end
            end
            if (pred_hit) pending_starts = {pending_starts, pred_start};
         end
      end
   end

   // result side: random stall segments, plus one long hold on request
   initial begin
      int mode;
      int n;
      rsp_bus.ready <= 1'b0;
      forever begin
         if (long_hold_wanted) begin
            @(negedge clock);
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            long_hold_wanted = 1'b0;
         end else begin
            mode = $urandom_range(0, 3);
            n    = $urandom_range(4, 60);
            repeat (n) begin
               @(negedge clock);
               case (mode)
                  0:       rsp_bus.ready <= 1'b1;
                  1:       rsp_bus.ready <= ($urandom_range(0, 3) != 0);
                  2:       rsp_bus.ready <= ($urandom_range(0, 3) == 0);
                  default: rsp_bus.ready <= 1'b0;
               endcase
            end
         end
      end
   end

   task automatic send_sample(input logic [SAMPLE_W-1:0] s, input logic eos);
      if (burst_left == 0) begin
         req_bus.valid <= 1'b0;
         repeat (($urandom_range(0, 7) == 0) ? $urandom_range(20, 90) : $urandom_range(1, 5))
            @(negedge clock);
         burst_left = $urandom_range(1, 12);
      end
      req_bus.valid         <= 1'b1;
      req_bus.sample        <= s;
      req_bus.end_of_series <= eos;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
      @(negedge clock);
      burst_left--;
   endtask

   // block must be idle before a register write
   task automatic settle_block();
      req_bus.valid <= 1'b0;
      while (pending_starts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [CSR_DATA_BITS-1:0] d);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= d;
      do @(posedge clock); while (!(csr_bus.valid && csr_bus.ready));
      @(negedge clock);
      csr_bus.valid <= 1'b0;
      @(negedge clock);
   endtask

   function automatic void add_item(input logic [SAMPLE_W-1:0] s, input logic eos);
      stim_row_type entry;
      entry      = '{ROW_ITEM, s, eos, CSR_WINDOW_LENGTH, 1'b0, 1'b0, '0};
      stim_table = {stim_table, entry};
   endfunction

   function automatic void add_known(input logic [SAMPLE_W-1:0] s, input logic eos,
                                     input bit hit, input logic [POS_W-1:0] start);
      stim_row_type entry;
      entry      = '{ROW_ITEM, s, eos, CSR_WINDOW_LENGTH, 1'b1, hit, start};
      stim_table = {stim_table, entry};
   endfunction

   function automatic void add_csr(input csr_index_type idx, input logic [SAMPLE_W-1:0] d);
      stim_row_type entry;
      entry      = '{ROW_CSR, d, 1'b0, idx, 1'b0, 1'b0, '0};
      stim_table = {stim_table, entry};
   endfunction

   initial begin
      int unsigned phase_len [9];
      int unsigned phase_spr [9];
      int unsigned eff_len;
      int unsigned series_len;
      int          style;
      int          base;
      int          noise;
      int          v;
      int          sent;
      int          random_sent;
      logic        eos;

      phase_len             = '{5, 64, 127, 1, 0, 16, 0, 100, 2};
      phase_spr             = '{30, 300, 65535, 0, 50, 0, 0, 500, 65535};
      reset                 = 1'b1;
      req_bus.valid         <= 1'b0;
      req_bus.sample        <= '0;
      req_bus.end_of_series <= 1'b0;
      csr_bus.valid         <= 1'b0;
      csr_bus.index         <= CSR_WINDOW_LENGTH;
      csr_bus.data          <= '0;
      for (int i = 0; i < WINDOW_CELLS; i++) held[i] = '0;
      held_count       = 0;
      position         = '0;
      cfg_length       = RST_WINDOW_LENGTH;
      cfg_spread       = RST_MAX_SPREAD;
      errors           = 0;
      samples_taken    = 0;
      hits_seen        = 0;
      csr_writes       = 0;
      burst_left       = 0;
      long_hold_wanted = 1'b0;
      random_sent      = 0;

      // reset settings: length 8, spread 0
      for (int i = 0; i < 7; i++) add_known(16'h0000, 1'b0, 1'b0, '0);
      add_known(16'h0000, 1'b0, 1'b1, 20'd1);
      add_known(16'hFFFF, 1'b0, 1'b0, '0);
      add_known(16'hFFFF, 1'b1, 1'b0, '0);
      add_csr(CSR_WINDOW_LENGTH, 16'd1);
      add_known(16'hFFFF, 1'b0, 1'b1, 20'd1);
      add_known(16'h0000, 1'b1, 1'b1, 20'd2);
      // zero length acts as one
      add_csr(CSR_WINDOW_LENGTH, 16'd0);
      add_known(16'h1234, 1'b0, 1'b1, 20'd1);
      add_known(16'h5555, 1'b1, 1'b1, 20'd2);
      add_csr(CSR_WINDOW_LENGTH, 16'd2);
      add_csr(CSR_MAX_SPREAD, 16'hFFFF);
      add_known(16'h0000, 1'b0, 1'b0, '0);
      add_known(16'hFFFF, 1'b0, 1'b1, 20'd1);
      add_known(16'h8000, 1'b1, 1'b1, 20'd2);
      add_csr(CSR_WINDOW_LENGTH, 16'hFF83);
      add_csr(CSR_MAX_SPREAD, 16'd1);
      add_item(16'd100, 1'b0);
      add_item(16'd101, 1'b0);
      add_item(16'd100, 1'b0);
      add_item(16'd102, 1'b0);
      // length change in the middle of a series
      add_csr(CSR_WINDOW_LENGTH, 16'd2);
      add_item(16'd102, 1'b1);

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (stim_table[r]) begin
         if (stim_table[r].kind == ROW_CSR) begin
            settle_block();
            write_register(stim_table[r].idx, stim_table[r].value);
         end else begin
            table_notes = {table_notes, stim_table[r]};
            send_sample(stim_table[r].value, stim_table[r].eos);
         end
      end

      for (int p = 0; p < 9; p++) begin
         if (p == 6) begin
            phase_len[p] = $urandom_range(1, 64);
            phase_spr[p] = $urandom_range(0, 65535);
         end
         settle_block();
         write_register(CSR_WINDOW_LENGTH,
                        CSR_DATA_BITS'(phase_len[p] | ($urandom_range(0, 511) << 7)));
         write_register(CSR_MAX_SPREAD, CSR_DATA_BITS'(phase_spr[p]));
         eff_len = (phase_len[p] == 0) ? 1 :
                   ((phase_len[p] > WINDOW_CELLS) ? WINDOW_CELLS : phase_len[p]);
         sent = 0;
         while (sent < 100) begin
            series_len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, eff_len)
                                                    : eff_len + $urandom_range(0, 40);
            style = $urandom_range(0, 9);
            base  = $urandom_range(0, 65535);
            noise = $urandom_range(0, 1) ? phase_spr[p]
                                         : phase_spr[p] + phase_spr[p] / 16 + 2;
            for (int k = 0; k < series_len && sent < 100; k++) begin
               case (style)
                  6:       v = base;
                  7:       v = $urandom_range(0, 1) ? 65535 : 0;
                  8, 9:    v = $urandom_range(0, 65535);
                  default: v = base + $urandom_range(0, noise);
               endcase
               if (v > 65535) v = 65535;
               eos = (k == series_len - 1) || ($urandom_range(0, 60) == 0);
               send_sample(SAMPLE_W'(v), eos);
               sent++;
               random_sent++;
               if (random_sent == 400) long_hold_wanted = 1'b1;
            end
         end
      end

      settle_block();
      errors += pending_starts.size();
      $display("run covered %0d samples and %0d register writes over the table and 9 phases",
               samples_taken, csr_writes);
      $display("%0d window starts reported, %0d errors", hits_seen, errors);
      if (errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
